@@ rtl/tlvw_pkg.sv @@
`default_nettype none
package tlvw_pkg;

	localparam int TYPE_SLOTS_DEF  = 64;
	localparam int OFFSET_BITS_DEF = 16;

	// generation tag kept per bitmap entry; an entry counts as seen when its tag
	// matches the current buffer's tag
	localparam int EPOCH_BITS = 8;

	localparam logic [5:0] MAX_TYPE_RST = 6'd63;

	localparam logic [1:0] KIND_RECORD = 2'd0;
	localparam logic [1:0] KIND_OK     = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [1:0] ERR_TRUNC   = 2'd0;
	localparam logic [1:0] ERR_SHORT   = 2'd1;
	localparam logic [1:0] ERR_OVERRUN = 2'd2;
	localparam logic [1:0] ERR_PAD     = 2'd3;

	typedef struct packed {
		logic capture;   // register read data for the word entering the output stage
		logic mark;      // record a sighting of the addressed type
		logic buf_end;   // buffer finished: start a fresh generation
	} seen_req_t;

endpackage
`default_nettype wire

@@ rtl/tlvw_ifs.sv @@
`default_nettype none
interface tlvw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface tlvw_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [15:0] attr_type;
	logic [15:0] attr_offset;
	logic [15:0] attr_length;
	logic        first_of_type;
	logic [1:0]  error_code;
	logic        last_result;

	modport source (output valid, output result_kind, output attr_type, output attr_offset,
		output attr_length, output first_of_type, output error_code, output last_result,
		input ready);
	modport sink (input valid, input result_kind, input attr_type, input attr_offset,
		input attr_length, input first_of_type, input error_code, input last_result,
		output ready);
endinterface

interface tlvw_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] max_type;

	modport source (output valid, output max_type, input ready);
	modport sink   (input valid, input max_type, output ready);
endinterface
`default_nettype wire

@@ rtl/tlv_attribute_walker.sv @@
`default_nettype none
// channel    | dir | word
// -----------+-----+------------------------------------------------------------
// buf_bytes  | in  | data_byte, end_of_buffer
// results    | out | result_kind, attr_type/offset/length, first_of_type,
//            |     | error_code, last_result
// cfg        | in  | max_type
//
// One byte per cycle while no sweep or stall holds it; a byte that yields a record and
// a final word holds the input until both words drain from the single output stage.
// The seen-type table is a memory tagged with a buffer generation; after reset, and
// once every 2^8-1 buffers, a sweep clears it slot by slot with input held off.
// Output back-pressure stalls input only when the output stage cannot be emptied.
module tlv_attribute_walker #(
	parameter int TYPE_SLOTS  = tlvw_pkg::TYPE_SLOTS_DEF,
	parameter int OFFSET_BITS = tlvw_pkg::OFFSET_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tlvw_in_if.sink     buf_bytes,
	tlvw_out_if.source  results,
	tlvw_cfg_if.sink    cfg
);
	import tlvw_pkg::*;

	localparam int AW = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_PADDING = 2'd2;
	localparam logic [1:0] PH_DROP    = 2'd3;

	logic [5:0]             max_type_q;
	logic [OFFSET_BITS-1:0] byte_offset_q;
	logic [23:0]            hdr_q;
	logic [15:0]            type_q;
	logic [15:0]            len_q;
	logic [15:0]            skip_q;
	logic [1:0]             phase_q;

	logic [23:0] hdr_n;
	logic [15:0] type_n, len_n, skip_n, skip_dec;
	logic [1:0]  phase_n;
	logic        rec, ok, err;
	logic [1:0]  code;
	logic [15:0] rec_type, rec_len;
	logic [15:0] hdr_len, hdr_type;
	logic [1:0]  pad;
	logic [OFFSET_BITS-1:0] rec_off;
	logic        tracked;
	logic        eob;
	logic [7:0]  b;

	logic        rec_pend_s1, fin_pend_s1, tracked_s1;
	logic [15:0] type_s1, off_s1, len_s1;
	logic [1:0]  kind_s1, err_s1;

	logic        accept, out_fire, drain_done, mem_busy, seen;
	seen_req_t   mreq;
	logic [AW-1:0] maddr;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_type_q <= MAX_TYPE_RST;
		end else if (cfg.valid) begin
			max_type_q <= cfg.max_type;
		end
	end

	assign b        = buf_bytes.data_byte;
	assign eob      = buf_bytes.end_of_buffer;
	assign hdr_len  = hdr_q[15:0];
	assign hdr_type = {b, hdr_q[23:16]};
	assign skip_dec = skip_q - 16'd1;
	assign pad      = 2'd0 - len_q[1:0];

	always_comb begin
		hdr_n    = hdr_q;
		type_n   = type_q;
		len_n    = len_q;
		skip_n   = skip_q;
		phase_n  = phase_q;
		rec      = 1'b0;
		ok       = 1'b0;
		err      = 1'b0;
		code     = ERR_TRUNC;
		rec_type = type_q;
		rec_len  = len_q;
		unique case (phase_q)
			PH_HEADER: begin
				unique case (byte_offset_q[1:0])
					2'd0: hdr_n[7:0]   = b;
					2'd1: hdr_n[15:8]  = b;
					2'd2: hdr_n[23:16] = b;
					default: ;
				endcase
				if (byte_offset_q[1:0] != 2'd3) begin
					if (eob) begin
						err  = 1'b1;
						code = ERR_TRUNC;
					end
				end else if (hdr_len < 16'd4) begin
					err  = 1'b1;
					code = ERR_SHORT;
				end else begin
					len_n    = hdr_len;
					type_n   = hdr_type;
					rec_len  = hdr_len;
					rec_type = hdr_type;
					if (hdr_len == 16'd4) begin
						rec = 1'b1;
						ok  = eob;
					end else begin
						skip_n  = hdr_len - 16'd4;
						phase_n = PH_PAYLOAD;
						if (eob) begin
							err  = 1'b1;
							code = ERR_OVERRUN;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				skip_n = skip_dec;
				if (skip_dec == 16'd0) begin
					rec = 1'b1;
					if (eob) begin
						ok = 1'b1;
					end else if (pad != 2'd0) begin
						skip_n  = 16'(pad);
						phase_n = PH_PADDING;
					end else begin
						phase_n = PH_HEADER;
					end
				end else if (eob) begin
					err  = 1'b1;
					code = ERR_OVERRUN;
				end
			end
			PH_PADDING: begin
				skip_n = skip_dec;
				if (skip_dec == 16'd0) begin
					phase_n = PH_HEADER;
					ok      = eob;
				end else if (eob) begin
					err  = 1'b1;
					code = ERR_PAD;
				end
			end
			PH_DROP: ;
			default: ;
		endcase
		if (err) begin
			phase_n = PH_DROP;
		end
		if (eob) begin
			phase_n = PH_HEADER;
			skip_n  = '0;
		end
	end

	// header offset: the record's byte closes the attribute
	assign rec_off = byte_offset_q + OFFSET_BITS'(1) - OFFSET_BITS'(rec_len);
	assign tracked = rec && (rec_type <= {10'd0, max_type_q})
		&& (32'(rec_type) < TYPE_SLOTS);

	assign drain_done = out_fire && (rec_pend_s1 ? !fin_pend_s1 : 1'b1);
	assign buf_bytes.ready = !mem_busy && (!(rec_pend_s1 || fin_pend_s1) || drain_done);
	assign accept   = buf_bytes.valid && buf_bytes.ready;
	assign out_fire = results.valid && results.ready;

	assign mreq.capture = accept;
	assign mreq.mark    = accept && tracked;
	assign mreq.buf_end = accept && eob;
	assign maddr        = AW'(rec_type);

	tlvw_seen_mem #(
		.TYPE_SLOTS(TYPE_SLOTS)
	) u_seen (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.addr  (maddr),
		.busy  (mem_busy),
		.seen  (seen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			phase_q       <= PH_HEADER;
			skip_q        <= '0;
			len_q         <= '0;
			type_q        <= '0;
			hdr_q         <= '0;
		end else if (accept) begin
			byte_offset_q <= eob ? '0 : byte_offset_q + OFFSET_BITS'(1);
			phase_q       <= phase_n;
			skip_q        <= skip_n;
			len_q         <= len_n;
			type_q        <= type_n;
			hdr_q         <= hdr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_pend_s1 <= 1'b0;
			fin_pend_s1 <= 1'b0;
		end else if (accept) begin
			rec_pend_s1 <= rec;
			fin_pend_s1 <= err || ok;
		end else if (out_fire) begin
			if (rec_pend_s1) begin
				rec_pend_s1 <= 1'b0;
			end else begin
				fin_pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1    <= rec_type;
			off_s1     <= 16'(rec_off);
			len_s1     <= rec_len;
			tracked_s1 <= tracked;
			kind_s1    <= err ? KIND_ERROR : KIND_OK;
			err_s1     <= err ? code : ERR_TRUNC;
		end
	end

	always_comb begin
		results.valid = rec_pend_s1 || fin_pend_s1;
		if (rec_pend_s1) begin
			results.result_kind   = KIND_RECORD;
			results.attr_type     = type_s1;
			results.attr_offset   = off_s1;
			results.attr_length   = len_s1;
			results.first_of_type = tracked_s1 && !seen;
			results.error_code    = ERR_TRUNC;
			results.last_result   = !fin_pend_s1;
		end else begin
			results.result_kind   = kind_s1;
			results.attr_type     = '0;
			results.attr_offset   = '0;
			results.attr_length   = '0;
			results.first_of_type = 1'b0;
			results.error_code    = err_s1;
			results.last_result   = 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/tlvw_seen_mem.sv @@
`default_nettype none
module tlvw_seen_mem #(
	parameter int TYPE_SLOTS = tlvw_pkg::TYPE_SLOTS_DEF,
	localparam int AW = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tlvw_pkg::seen_req_t req,
	input  wire logic [AW-1:0]     addr,
	output logic                   busy,
	output logic                   seen
);
	import tlvw_pkg::*;

	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = {EPOCH_BITS{1'b1}};
	localparam logic [AW-1:0]         LAST_SLOT   = AW'(TYPE_SLOTS - 1);

	logic [EPOCH_BITS-1:0] mem [TYPE_SLOTS];
	logic [EPOCH_BITS-1:0] rdata_q;
	logic [EPOCH_BITS-1:0] rd_epoch_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic                  clr_q;
	logic [AW-1:0]         clr_cnt_q;

	// tag zero is never a live generation, so a swept entry reads as unseen
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (req.mark) begin
			mem[addr] <= epoch_q;
		end
		if (req.capture) begin
			rdata_q    <= mem[addr];
			rd_epoch_q <= epoch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= EPOCH_FIRST;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == LAST_SLOT) begin
					clr_q <= 1'b0;
				end
			end
			if (req.buf_end) begin
				if (epoch_q == EPOCH_LAST) begin
					// tags about to be reused: sweep the table
					epoch_q   <= EPOCH_FIRST;
					clr_q     <= 1'b1;
					clr_cnt_q <= '0;
				end else begin
					epoch_q <= epoch_q + EPOCH_BITS'(1);
				end
			end
		end
	end

	assign busy = clr_q;
	assign seen = (rdata_q == rd_epoch_q);

endmodule
`default_nettype wire

@@ tb/sv/tb_tlv_attribute_walker.sv @@
`timescale 1ns / 1ps
module tb_tlv_attribute_walker;
	import tlvw_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE      = 80;
	localparam int PHASES      = 6;
	localparam int PHASE_BYTES = 160;

	typedef enum logic [1:0] {WALK_HEADER, WALK_PAYLOAD, WALK_PADDING, WALK_DROP} walk_phase_t;

	typedef struct packed {
		logic [7:0] octet;
		logic       eob;
	} buf_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] attr_type;
		logic [15:0] offset;
		logic [15:0] length;
		logic        first;
		logic [1:0]  code;
		logic        last;
	} result_word_t;

	logic clk;
	logic arst_n;

	tlvw_in_if  buf_bytes();
	tlvw_out_if results();
	tlvw_cfg_if cfg();

	tlv_attribute_walker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.buf_bytes(buf_bytes),
		.results  (results),
		.cfg      (cfg)
	);

	buf_item_t    feed_q[$];
	result_word_t expected_words[$];
	logic [7:0]   scratch[$];

	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int          idle_rate;
	int          send_gap;
	int          recv_stall;

	// walker state
	walk_phase_t walk_phase = WALK_HEADER;
	logic [15:0] byte_pos = '0;
	logic [31:0] hdr_bits = '0;
	logic [15:0] left = '0;
	logic [15:0] attr_len = '0;
	logic [63:0] seen_mask = '0;
	logic [5:0]  type_ceiling;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic result_word_t attr_record();
		result_word_t w;
		logic [15:0]  ty;
		w = '0;
		ty = hdr_bits[31:16];
		w.kind = KIND_RECORD;
		w.attr_type = ty;
		w.offset = byte_pos + 16'd1 - attr_len;
		w.length = attr_len;
		if (ty <= {10'd0, type_ceiling} && ty < 16'd64) begin
			w.first = ~seen_mask[ty[5:0]];
			seen_mask[ty[5:0]] = 1'b1;
		end
		return w;
	endfunction

	task automatic walk_byte(input logic [7:0] octet, input logic eob);
		result_word_t words[2];
		int           n;
		logic [1:0]   slot;
		logic [15:0]  len;
		bit           failed;
		bit           clean;
		logic [1:0]   code;
		n = 0;
		failed = 0;
		clean = 0;
		code = ERR_TRUNC;
		words[0] = '0;
		words[1] = '0;
		case (walk_phase)
		WALK_HEADER: begin
			slot = byte_pos[1:0];
			if (slot == 2'd0)
				hdr_bits = {24'd0, octet};
			else
				hdr_bits = hdr_bits | ({24'd0, octet} << (8 * slot));
			if (slot != 2'd3) begin
				if (eob) begin
					failed = 1;
					code = ERR_TRUNC;
				end
			end else begin
				len = hdr_bits[15:0];
				if (len < 16'd4) begin
					failed = 1;
					code = ERR_SHORT;
				end else begin
					attr_len = len;
					if (len == 16'd4) begin
						words[n] = attr_record();
						n++;
						clean = eob;
					end else begin
						left = len - 16'd4;
						walk_phase = WALK_PAYLOAD;
						if (eob) begin
							failed = 1;
							code = ERR_OVERRUN;
						end
					end
				end
			end
		end
		WALK_PAYLOAD: begin
			left = left - 16'd1;
			if (left == 16'd0) begin
				words[n] = attr_record();
				n++;
				if (eob) begin
					clean = 1;
				end else if (attr_len[1:0] != 2'd0) begin
					left = 16'd4 - {14'd0, attr_len[1:0]};
					walk_phase = WALK_PADDING;
				end else begin
					walk_phase = WALK_HEADER;
				end
			end else if (eob) begin
				failed = 1;
				code = ERR_OVERRUN;
			end
		end
		WALK_PADDING: begin
			left = left - 16'd1;
			if (left == 16'd0) begin
				walk_phase = WALK_HEADER;
				clean = eob;
			end else if (eob) begin
				failed = 1;
				code = ERR_PAD;
			end
		end
		default: ;
		endcase

		if (failed) begin
			words[n].kind = KIND_ERROR;
			words[n].code = code;
			n++;
			walk_phase = WALK_DROP;
		end else if (clean) begin
			words[n].kind = KIND_OK;
			n++;
		end
		if (n > 0)
			words[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_words.push_back(words[i]);

		byte_pos = byte_pos + 16'd1;
		if (eob) begin
			byte_pos = '0;
			walk_phase = WALK_HEADER;
			left = '0;
			seen_mask = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		result_word_t w;
		if (expected_words.size() == 0) begin
			$error("result word with nothing expected: kind %0d type %0h", results.result_kind,
				results.attr_type);
			mismatches++;
		end else begin
			w = expected_words.pop_front();
			check_field("result_kind", {14'd0, w.kind}, {14'd0, results.result_kind});
			check_field("attr_type", w.attr_type, results.attr_type);
			check_field("attr_offset", w.offset, results.attr_offset);
			check_field("attr_length", w.length, results.attr_length);
			check_field("first_of_type", {15'd0, w.first}, {15'd0, results.first_of_type});
			check_field("error_code", {14'd0, w.code}, {14'd0, results.error_code});
			check_field("last_result", {15'd0, w.last}, {15'd0, results.last_result});
		end
	endtask

	// byte driver
	always @(posedge clk) begin
		buf_item_t it;
		if (!arst_n) begin
			buf_bytes.valid <= 1'b0;
			buf_bytes.data_byte <= '0;
			buf_bytes.end_of_buffer <= 1'b0;
			send_gap = 0;
		end else begin
			if (buf_bytes.valid && buf_bytes.ready)
				walk_byte(buf_bytes.data_byte, buf_bytes.end_of_buffer);
			if (!buf_bytes.valid || buf_bytes.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					buf_bytes.valid <= 1'b0;
				end else if (feed_q.size() != 0 && idle_rate != 0 &&
						$urandom_range(99) < idle_rate) begin
					send_gap = $urandom_range(16, 0);
					buf_bytes.valid <= 1'b0;
				end else if (feed_q.size() != 0) begin
					it = feed_q.pop_front();
					buf_bytes.valid <= 1'b1;
					buf_bytes.data_byte <= it.octet;
					buf_bytes.end_of_buffer <= it.eob;
				end else begin
					buf_bytes.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (results.valid && results.ready)
				check_result();
			if (recv_stall > 0) begin
				recv_stall--;
				results.ready <= 1'b0;
			end else if (idle_rate != 0 && $urandom_range(99) < idle_rate) begin
				recv_stall = $urandom_range(16, 0);
				results.ready <= 1'b0;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	function automatic logic [15:0] pick_type();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 16'($urandom_range(15));
		if (r < 85) return 16'($urandom_range(80));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 85) return 16'($urandom_range(19, 4));
		if (r < 95) return 16'($urandom_range(60, 20));
		return 16'd4;
	endfunction

	task automatic add_header(input logic [15:0] len, input logic [15:0] ty);
		scratch.push_back(len[7:0]);
		scratch.push_back(len[15:8]);
		scratch.push_back(ty[7:0]);
		scratch.push_back(ty[15:8]);
	endtask

	task automatic add_attr(input logic [15:0] ty, input logic [15:0] len, input bit padded);
		add_header(len, ty);
		for (int i = 4; i < int'(len); i++)
			scratch.push_back(8'($urandom));
		if (padded)
			for (int i = 0; i < int'((4 - len[1:0]) & 3); i++)
				scratch.push_back(8'($urandom));
	endtask

	task automatic flush_buffer(inout int count);
		buf_item_t it;
		for (int i = 0; i < scratch.size(); i++) begin
			it.octet = scratch[i];
			it.eob = (i == scratch.size() - 1);
			feed_q.push_back(it);
		end
		count += scratch.size();
		scratch.delete();
	endtask

	task automatic queue_random_buffer(inout int count);
		int style;
		int n;
		int cut;
		style = $urandom_range(99);
		if (style < 70) begin
			n = $urandom_range(6, 1);
			for (int i = 0; i < n; i++)
				add_attr(pick_type(), pick_len(), (i != n - 1) || $urandom_range(1));
		end else if (style < 80) begin
			// clean attributes cut off anywhere
			n = $urandom_range(4, 1);
			for (int i = 0; i < n; i++)
				add_attr(pick_type(), pick_len(), 1);
			cut = $urandom_range(scratch.size() - 1, 1);
			while (scratch.size() > cut)
				void'(scratch.pop_back());
		end else if (style < 88) begin
			n = $urandom_range(2);
			for (int i = 0; i < n; i++)
				add_attr(pick_type(), pick_len(), 1);
			add_header(16'($urandom_range(3)), pick_type());
			n = $urandom_range(6);
			for (int i = 0; i < n; i++)
				scratch.push_back(8'($urandom));
		end else if (style < 95) begin
			n = $urandom_range(20, 1);
			for (int i = 0; i < n; i++)
				scratch.push_back(8'($urandom));
		end else begin
			// declared length runs past the end
			n = $urandom_range(2);
			for (int i = 0; i < n; i++)
				add_attr(pick_type(), pick_len(), 1);
			add_header(16'($urandom_range(65535, 8)), pick_type());
			n = $urandom_range(3);
			for (int i = 0; i < n; i++)
				scratch.push_back(8'($urandom));
		end
		flush_buffer(count);
	endtask

	task automatic queue_directed(inout int count);
		// header-only record, then an unpadded final attribute with all-ones type
		add_header(16'd4, 16'd0);
		add_header(16'd5, 16'hFFFF);
		scratch.push_back(8'hFF);
		flush_buffer(count);
		// padding cut short
		add_header(16'd5, 16'd2);
		scratch.push_back(8'h7F);
		scratch.push_back(8'h00);
		flush_buffer(count);
		// short length, trailing byte dropped
		add_header(16'd2, 16'd1);
		scratch.push_back(8'hA5);
		flush_buffer(count);
		// ends inside a header
		scratch.push_back(8'h5A);
		flush_buffer(count);
		// overrun at the largest length
		add_header(16'hFFFF, 16'd7);
		flush_buffer(count);
	endtask

	task automatic write_max_type(input logic [5:0] value);
		cfg.valid <= 1'b1;
		cfg.max_type <= value;
		do @(posedge clk); while (!cfg.ready);
		type_ceiling = value;
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (feed_q.size() != 0 || buf_bytes.valid || expected_words.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int         queued;
		logic [5:0] ceiling;
		cfg.valid = 1'b0;
		cfg.max_type = MAX_TYPE_RST;
		arst_n = 1'b0;
		idle_rate = 0;
		type_ceiling = MAX_TYPE_RST;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0, 3: ceiling = 6'd63;
			1: ceiling = 6'd0;
			5: ceiling = 6'd1;
			default: ceiling = 6'($urandom_range(62, 1));
			endcase
			write_max_type(ceiling);
			case (ph)
			0: idle_rate = 20;
			1: idle_rate = 10;
			2: idle_rate = 35;
			3: idle_rate = 5;
			4: idle_rate = 15;
			default: idle_rate = 0;
			endcase
			queued = 0;
			if (ph == 0)
				queue_directed(queued);
			queued = 0;
			while (queued < PHASE_BYTES)
				queue_random_buffer(queued);
			drain();
		end

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ tlv_attribute_walker.f @@
rtl/tlvw_pkg.sv
rtl/tlvw_ifs.sv
rtl/tlvw_seen_mem.sv
rtl/tlv_attribute_walker.sv
tb/sv/tb_tlv_attribute_walker.sv
